// ----- rtl/crfr_pkg.sv -----
// ----------------------------------------------------------------------------
// crfr_pkg
// shared types and constants for the checksummed record frame receiver
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package crfr_pkg;

  // frame format
  localparam logic [7:0]  HEADER_BYTE   = 8'h06;
  localparam int unsigned LIMIT_MUL     = 7;
  localparam int unsigned LIMIT_BASE    = 8;
  localparam int unsigned STORE_SPAN    = 14;

  // position counter
  localparam int unsigned POS_W         = 11;
  localparam logic [POS_W-1:0] POS_MAX  = '1;

  // capture store
  localparam int unsigned CAPTURE_DEPTH = 16;

  // request codes
  typedef enum logic [1:0] {
    REQ_BYTE  = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_READ  = 2'd2
  } req_t;

  // result status codes
  typedef enum logic [3:0] {
    ST_IGNORED = 4'd0,
    ST_HDR_OK  = 4'd1,
    ST_HDR_BAD = 4'd2,
    ST_COUNT   = 4'd3,
    ST_BODY    = 4'd4,
    ST_SUM_OK  = 4'd5,
    ST_SUM_BAD = 4'd6,
    ST_CLEARED = 4'd7,
    ST_READ    = 4'd8
  } status_t;

endpackage

// ----- rtl/checksummed_record_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// checksummed_record_frame_receiver
// result: registered output, valid in the cycle after an input is accepted
// throughput: one item per cycle while out_ready is high
// rate is set by the single-pass state update and the capture store port,
// which is written and read once per cycle
// reset: synchronous rst clears all frame state, valid bits and the output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module checksummed_record_frame_receiver #(
  parameter int unsigned CAPTURE_DEPTH = crfr_pkg::CAPTURE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,

  // input item channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] req_type,
  input  logic [7:0] rx_byte,
  input  logic [3:0] read_index,

  // result item channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] status,
  output logic [7:0] read_data,
  output logic [7:0] record_count
);

  localparam int unsigned ADDR_W = (CAPTURE_DEPTH > 1) ? $clog2(CAPTURE_DEPTH) : 1;
  localparam int unsigned POS_W  = crfr_pkg::POS_W;
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(CAPTURE_DEPTH - 1);

  // --------------------------------------------------------------------------
  // frame state
  // --------------------------------------------------------------------------
  logic [POS_W-1:0]         byte_position;
  logic [7:0]               count_reg;
  logic [POS_W-1:0]         frame_limit;
  logic [7:0]               running_sum;
  logic [ADDR_W-1:0]        write_pointer;
  logic [CAPTURE_DEPTH-1:0] entry_valid;

  logic [POS_W-1:0]         byte_position_next;
  logic [7:0]               count_reg_next;
  logic [POS_W-1:0]         frame_limit_next;
  logic [7:0]               running_sum_next;
  logic [ADDR_W-1:0]        write_pointer_next;
  logic                     clear_all;
  logic                     store_we;
  crfr_pkg::status_t        status_next;

  // capture store and its registered read port
  logic [7:0]               capture_store [CAPTURE_DEPTH];
  logic [7:0]               rd_q;
  logic                     rd_sel;
  logic                     rd_sel_q;
  logic [ADDR_W-1:0]        rd_addr;
  logic                     rd_in_range;

  // result register
  crfr_pkg::status_t        status_q;

  logic                     accept;
  crfr_pkg::req_t           req;

  // the output register parts the two sides; a new item enters whenever the
  // current result leaves in the same cycle or there is no result waiting
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign req      = crfr_pkg::req_t'(req_type);

  // read address: indexes past the store depth read as zero
  assign rd_in_range = (int'(read_index) < int'(CAPTURE_DEPTH));
  assign rd_addr     = ADDR_W'(read_index);
  assign rd_sel      = (req == crfr_pkg::REQ_READ) && rd_in_range && entry_valid[rd_addr];

  // --------------------------------------------------------------------------
  // per-item state update
  // --------------------------------------------------------------------------
  always_comb begin
    logic [POS_W-1:0] pos;
    logic [POS_W:0]   pos_ext;
    logic [POS_W:0]   limit_ext;
    logic             in_body;
    logic             in_tail;

    byte_position_next = byte_position;
    count_reg_next     = count_reg;
    frame_limit_next   = frame_limit;
    running_sum_next   = running_sum;
    write_pointer_next = write_pointer;
    clear_all          = 1'b0;
    store_we           = 1'b0;
    status_next        = crfr_pkg::ST_IGNORED;

    // saturating position of the byte now arriving
    pos       = (byte_position != crfr_pkg::POS_MAX) ? byte_position + 1'b1 : byte_position;
    pos_ext   = {1'b0, pos};
    limit_ext = {1'b0, frame_limit};
    in_body   = (pos >= POS_W'(3)) && (pos <= frame_limit);
    // last STORE_SPAN bytes of the body land in the capture store, when the frame limit is at least STORE_SPAN
    in_tail   = (frame_limit >= POS_W'(crfr_pkg::STORE_SPAN)) &&
                (pos_ext + (POS_W+1)'(crfr_pkg::STORE_SPAN) > limit_ext);

    case (req)
      crfr_pkg::REQ_BYTE: begin
        byte_position_next = pos;
        if (pos == POS_W'(1)) begin
          // header byte
          if (rx_byte != crfr_pkg::HEADER_BYTE) begin
            clear_all   = 1'b1;
            status_next = crfr_pkg::ST_HDR_BAD;
          end else begin
            status_next = crfr_pkg::ST_HDR_OK;
          end
        end else if (pos == POS_W'(2)) begin
          // record count: limit = 7n + 8, sum seeded with n
          count_reg_next   = rx_byte;
          frame_limit_next = ({3'b000, rx_byte} << 3) - {3'b000, rx_byte} +
                             POS_W'(crfr_pkg::LIMIT_BASE);
          running_sum_next = rx_byte;
          status_next      = crfr_pkg::ST_COUNT;
        end else if (in_body) begin
          running_sum_next = running_sum + rx_byte;
          status_next      = crfr_pkg::ST_BODY;
          if (in_tail) begin
            store_we           = 1'b1;
            write_pointer_next = (write_pointer == ADDR_LAST) ? '0 : write_pointer + 1'b1;
          end
        end else if (pos_ext == limit_ext + 1'b1) begin
          // checksum byte
          if (rx_byte != running_sum) begin
            clear_all   = 1'b1;
            status_next = crfr_pkg::ST_SUM_BAD;
          end else begin
            status_next = crfr_pkg::ST_SUM_OK;
          end
        end
      end
      crfr_pkg::REQ_CLEAR: begin
        clear_all   = 1'b1;
        status_next = crfr_pkg::ST_CLEARED;
      end
      crfr_pkg::REQ_READ: begin
        status_next = crfr_pkg::ST_READ;
      end
      default: begin
        status_next = crfr_pkg::ST_IGNORED;
      end
    endcase
  end

  // frame state registers; a clear wipes everything including valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      count_reg     <= '0;
      frame_limit   <= '0;
      running_sum   <= '0;
      write_pointer <= '0;
      entry_valid   <= '0;
    end else if (accept) begin
      if (clear_all) begin
        byte_position <= '0;
        count_reg     <= '0;
        frame_limit   <= '0;
        running_sum   <= '0;
        write_pointer <= '0;
        entry_valid   <= '0;
      end else begin
        byte_position <= byte_position_next;
        count_reg     <= count_reg_next;
        frame_limit   <= frame_limit_next;
        running_sum   <= running_sum_next;
        write_pointer <= write_pointer_next;
        if (store_we) begin
          entry_valid[write_pointer] <= 1'b1;
        end
      end
    end
  end

  // capture store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (accept && store_we) begin
      capture_store[write_pointer] <= rx_byte;
    end
    if (accept && rd_sel) begin
      rd_q <= capture_store[rd_addr];
    end
  end

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      rd_sel_q  <= 1'b0;
      status_q  <= crfr_pkg::ST_IGNORED;
    end else begin
      if (accept) begin
        out_valid <= 1'b1;
        rd_sel_q  <= rd_sel;
        status_q  <= status_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // record count follows the state: it only moves on accept, which is when
  // the result register moves as well
  assign status       = status_q;
  assign read_data    = rd_sel_q ? rd_q : 8'd0;
  assign record_count = count_reg;

endmodule
